FILE: rtl/core/pgs_pkg.sv
// shared types and constants of the periodic gate schedule block
package pgs_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int DUR_W = 32;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = 5;
	localparam int OFF_W = 40;
	localparam int SUM_W = DUR_W + IDX_W;
	localparam int LEN_W = 17;
	localparam int BITS_W = LEN_W + 1;
	localparam int TPB_W = 24;
	localparam int XB_W = 12;
	localparam int XT_W = 24;
	localparam int PROD_W = BITS_W + TPB_W;
	localparam int TX_W = PROD_W - 8 + 1;
	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 4;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_STATUS = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_COUNT = 2'd1;
	localparam logic [1:0] ERR_ZERO_DUR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_OPEN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GB_ENABLE = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_KNOWN = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TPB = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRA_BITS = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXTRA_TICKS = 4'd7;

	typedef struct packed {
		logic [1:0] operation;
		logic packet_present;
		logic [LEN_W-1:0] packet_length;
		logic [3:0] entry_index;
		logic [DUR_W-1:0] entry_duration;
	} pgs_in_t;

	typedef struct packed {
		logic gate_open;
		logic can_pass;
		logic in_guard_band;
		logic guard_band_changed;
		logic [31:0] time_to_change;
		logic [1:0] error_code;
	} pgs_out_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic sum_step;
		logic div_step;
		logic walk_step;
		logic load;
		logic mul;
		logic fit;
	} pgs_cmd_t;

	typedef struct packed {
		logic restart_run;
		logic sum_last;
		logic div_last;
		logic walk_go;
	} pgs_stat_t;

endpackage

FILE: rtl/core/pgs_ctrl.sv
// controller state machine sequencing one item through the datapath
module pgs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  pgs_pkg::pgs_stat_t st,
	output pgs_pkg::pgs_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SUM, S_DIV, S_WALK, S_MUL, S_FIT
	} state_t;

	state_t state_q;
	logic slot_free;

	assign in_ready = (state_q == S_IDLE);
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_EXEC: cmd.exec = 1'b1;
			S_SUM: cmd.sum_step = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_WALK: begin
				cmd.walk_step = st.walk_go;
				cmd.load = !st.walk_go;
			end
			S_MUL: cmd.mul = 1'b1;
			S_FIT: cmd.fit = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= st.restart_run ? S_SUM : S_MUL;
				S_SUM: if (st.sum_last) state_q <= S_DIV;
				S_DIV: if (st.div_last) state_q <= S_WALK;
				S_WALK: if (!st.walk_go) state_q <= S_MUL;
				S_MUL: state_q <= S_FIT;
				S_FIT: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/pgs_dp.sv
// datapath: config registers, schedule table, countdown, restart divider and fit check
module pgs_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pgs_pkg::CFG_W-1:0] cfg_data,
	input  pgs_pkg::pgs_in_t in_data,
	input  pgs_pkg::pgs_cmd_t cmd,
	output pgs_pkg::pgs_stat_t st,
	output pgs_pkg::pgs_out_t out_data
);

	localparam int DW = pgs_pkg::DUR_W;
	localparam int SW = pgs_pkg::SUM_W;
	localparam int OW = pgs_pkg::OFF_W;
	localparam int CW = pgs_pkg::CNT_W;
	localparam int IW = pgs_pkg::IDX_W;

	// configuration
	logic init_open_q, gbe_q, rk_q;
	logic [OW-1:0] start_off_q;
	logic [CW-1:0] ent_cnt_q;
	logic [pgs_pkg::TPB_W-1:0] tpb_q;
	logic [pgs_pkg::XB_W-1:0] xbits_q;
	logic [pgs_pkg::XT_W-1:0] xticks_q;

	// schedule state
	pgs_pkg::pgs_in_t item_q;
	logic [DW-1:0] table_q [pgs_pkg::MAX_ENTRIES];
	logic open_q, guard_q, pend_q, run_q, upd_q;
	logic [DW-1:0] rem_q;
	logic [IW-1:0] next_q;
	logic [CW-1:0] act_q, idx_q;
	logic [pgs_pkg::LEN_W-1:0] pbits_q;
	logic [1:0] err_q;
	logic [SW-1:0] sum_q, divr_q;
	logic [OW-1:0] dvd_q;
	logic [5:0] bcnt_q;
	logic [pgs_pkg::PROD_W-1:0] prod_s1;

	logic [IW-1:0] rd_addr, next_adv;
	logic [DW-1:0] rd_dur;
	logic [CW-1:0] nxt_inc;
	logic cnt_ok, walk_go;
	logic [SW:0] trial;
	logic [pgs_pkg::BITS_W-1:0] bits;
	logic [pgs_pkg::TX_W-1:0] tx;
	logic fits, g_new, guard_nxt;

	assign rd_addr = cmd.sum_step ? idx_q[IW-1:0] : next_q;
	assign rd_dur = table_q[rd_addr];
	assign nxt_inc = CW'(next_q) + CW'(1);
	assign next_adv = (nxt_inc >= act_q) ? '0 : nxt_inc[IW-1:0];
	assign cnt_ok = !ent_cnt_q[0] && (ent_cnt_q <= CW'(pgs_pkg::MAX_ENTRIES));
	assign trial = {divr_q, dvd_q[OW-1]};
	assign walk_go = (idx_q < act_q) && (divr_q != '0) && (divr_q >= SW'(rd_dur));

	assign st.restart_run = (item_q.operation == pgs_pkg::OP_RESTART) && cnt_ok
		&& (ent_cnt_q != '0);
	assign st.sum_last = (idx_q == act_q - CW'(1));
	assign st.div_last = (bcnt_q == 6'(OW - 1));
	assign st.walk_go = walk_go;

	assign bits = pgs_pkg::BITS_W'(pbits_q) + pgs_pkg::BITS_W'(xbits_q);
	// transmit time rounded up to whole ticks
	assign tx = pgs_pkg::TX_W'((prod_s1 + pgs_pkg::PROD_W'(255)) >> 8)
		+ pgs_pkg::TX_W'(xticks_q);
	assign fits = open_q && pend_q
		&& (!rk_q || !gbe_q || !run_q || (tx <= pgs_pkg::TX_W'(rem_q)));
	assign g_new = open_q && pend_q && !fits;
	assign guard_nxt = upd_q ? g_new : guard_q;

	always_ff @(posedge clk) begin
		if (cmd.exec && item_q.operation == pgs_pkg::OP_WRITE
				&& item_q.entry_duration != '0)
			table_q[item_q.entry_index[IW-1:0]] <= item_q.entry_duration;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_open_q <= 1'b0;
			start_off_q <= '0;
			ent_cnt_q <= '0;
			gbe_q <= 1'b0;
			rk_q <= 1'b0;
			tpb_q <= pgs_pkg::TPB_W'(256);
			xbits_q <= '0;
			xticks_q <= '0;
			open_q <= 1'b0;
			guard_q <= 1'b0;
			pend_q <= 1'b0;
			run_q <= 1'b0;
			upd_q <= 1'b0;
			rem_q <= '0;
			next_q <= '0;
			act_q <= '0;
			idx_q <= '0;
			pbits_q <= '0;
			err_q <= pgs_pkg::ERR_NONE;
			sum_q <= '0;
			divr_q <= '0;
			dvd_q <= '0;
			bcnt_q <= '0;
			prod_s1 <= '0;
			item_q <= '0;
			out_data <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pgs_pkg::REG_INIT_OPEN: init_open_q <= cfg_data[0];
					pgs_pkg::REG_START_OFFSET: start_off_q <= cfg_data[OW-1:0];
					pgs_pkg::REG_ENTRY_COUNT: ent_cnt_q <= cfg_data[CW-1:0];
					pgs_pkg::REG_GB_ENABLE: gbe_q <= cfg_data[0];
					pgs_pkg::REG_RATE_KNOWN: rk_q <= cfg_data[0];
					pgs_pkg::REG_TPB: tpb_q <= cfg_data[pgs_pkg::TPB_W-1:0];
					pgs_pkg::REG_EXTRA_BITS: xbits_q <= cfg_data[pgs_pkg::XB_W-1:0];
					pgs_pkg::REG_EXTRA_TICKS: xticks_q <= cfg_data[pgs_pkg::XT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept)
				item_q <= in_data;
			if (cmd.exec) begin
				err_q <= pgs_pkg::ERR_NONE;
				upd_q <= 1'b0;
				case (item_q.operation)
					pgs_pkg::OP_TICK: begin
						if (run_q) begin
							if (rem_q <= DW'(1)) begin
								open_q <= !open_q;
								rem_q <= rd_dur;
								next_q <= next_adv;
								upd_q <= 1'b1;
							end else begin
								rem_q <= rem_q - DW'(1);
							end
						end
					end
					pgs_pkg::OP_STATUS: begin
						pend_q <= item_q.packet_present;
						pbits_q <= item_q.packet_length;
						upd_q <= 1'b1;
					end
					pgs_pkg::OP_WRITE: begin
						if (item_q.entry_duration == '0)
							err_q <= pgs_pkg::ERR_ZERO_DUR;
					end
					pgs_pkg::OP_RESTART: begin
						if (!cnt_ok) begin
							err_q <= pgs_pkg::ERR_COUNT;
						end else begin
							open_q <= init_open_q;
							next_q <= '0;
							act_q <= ent_cnt_q;
							upd_q <= 1'b1;
							sum_q <= '0;
							idx_q <= '0;
							if (ent_cnt_q == '0) begin
								run_q <= 1'b0;
								rem_q <= '0;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.sum_step) begin
				sum_q <= sum_q + SW'(rd_dur);
				idx_q <= idx_q + CW'(1);
				if (st.sum_last) begin
					divr_q <= '0;
					dvd_q <= start_off_q;
					bcnt_q <= '0;
				end
			end
			// restoring remainder, one dividend bit per cycle
			if (cmd.div_step) begin
				divr_q <= (trial >= {1'b0, sum_q}) ? SW'(trial - {1'b0, sum_q}) : SW'(trial);
				dvd_q <= dvd_q << 1;
				bcnt_q <= bcnt_q + 6'd1;
				if (st.div_last)
					idx_q <= '0;
			end
			if (cmd.walk_step) begin
				open_q <= !open_q;
				divr_q <= divr_q - SW'(rd_dur);
				next_q <= next_adv;
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.load) begin
				rem_q <= (SW'(rd_dur) >= divr_q) ? rd_dur - divr_q[DW-1:0] : '0;
				next_q <= next_adv;
				run_q <= 1'b1;
			end
			if (cmd.mul)
				prod_s1 <= pgs_pkg::PROD_W'(bits) * pgs_pkg::PROD_W'(tpb_q);
			if (cmd.fit) begin
				guard_q <= guard_nxt;
				out_data.gate_open <= open_q;
				out_data.can_pass <= fits;
				out_data.in_guard_band <= guard_nxt;
				out_data.guard_band_changed <= upd_q && (g_new != guard_q);
				out_data.time_to_change <= run_q ? rem_q : '0;
				out_data.error_code <= err_q;
			end
		end
	end

endmodule

FILE: rtl/core/periodic_gate_schedule_with_guard_band_core.sv
// Periodic gate with guard band: a tick, packet status or table write item passes the
// states accept, execute, transmit-time multiply and fit check, in that order.
// A restart that starts a schedule of N entries adds, between execute and multiply, the
// table summing, the bit-serial modulo of the start offset by the cycle total, and the
// walking of whole entries and loading of the remainder (the remainder is below the
// total, so at most N - 1 entries are walked); summing, walking and loading share one
// table read port. One result beat is produced per input beat; the fit check waits while
// a stalled result is held, and the next item is taken while the result waits in the output register.
module periodic_gate_schedule_with_guard_band_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pgs_pkg::pgs_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output pgs_pkg::pgs_out_t out_data,
	input  logic cfg_we,
	input  logic [pgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pgs_pkg::CFG_W-1:0] cfg_data
);

	pgs_pkg::pgs_cmd_t cmd;
	pgs_pkg::pgs_stat_t st;

	pgs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st(st),
		.cmd(cmd)
	);

	pgs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.st(st),
		.out_data(out_data)
	);

endmodule

FILE: rtl/core/pgs_checker.sv
// port-level checks of the periodic gate block, bound to the top level
module pgs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pgs_pkg::pgs_out_t out_data
);

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.error_code == pgs_pkg::ERR_NONE
			|| out_data.error_code == pgs_pkg::ERR_COUNT
			|| out_data.error_code == pgs_pkg::ERR_ZERO_DUR))
		else $error("unknown error code");

	// guard band only while open
	a_guard_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_guard_band |-> out_data.gate_open)
		else $error("guard band reported with gate closed");

	// rejected items leave guard state alone
	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != pgs_pkg::ERR_NONE
			|-> !out_data.guard_band_changed)
		else $error("guard change on rejected item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

endmodule

bind periodic_gate_schedule_with_guard_band_core pgs_checker u_pgs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
